FILE: rtl/rtwa_pkg.sv
package rtwa_pkg;

  // Operation codes carried by an input beat.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 24;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_MS  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAGIC_TAG  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_HIGH  = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_MID   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BAND_LOW   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_EMPTY_AVG  = 3'd5;

  // Register reset values.
  localparam logic [15:0]       WINDOW_MS_RST  = 16'd2000;
  localparam logic [23:0]       MAGIC_TAG_RST  = 24'hC0FFEE;
  localparam logic signed [7:0] BAND_HIGH_RST  = -8'sd80;
  localparam logic signed [7:0] BAND_MID_RST   = -8'sd90;
  localparam logic signed [7:0] BAND_LOW_RST   = -8'sd100;
  localparam logic signed [7:0] EMPTY_AVG_RST  = -8'sd105;

  // Strength bands and their hues.
  localparam logic [1:0] BAND_STRONG = 2'd0;
  localparam logic [1:0] BAND_GOOD   = 2'd1;
  localparam logic [1:0] BAND_FAIR   = 2'd2;
  localparam logic [1:0] BAND_WEAK   = 2'd3;
  localparam logic [8:0] HUE_STRONG  = 9'd0;
  localparam logic [8:0] HUE_GOOD    = 9'd335;
  localparam logic [8:0] HUE_FAIR    = 9'd260;
  localparam logic [8:0] HUE_WEAK    = 9'd240;

  // Ring geometry and result count width.
  localparam int unsigned RING_DEPTH_DEFAULT = 64;
  localparam int unsigned COUNT_W            = 6;
  localparam logic [COUNT_W-1:0] COUNT_MAX   = 6'd63;

  // One stored sample.
  typedef struct packed {
    logic signed [7:0] rssi;
    logic [31:0]       stamp;
  } slot_t;

endpackage

FILE: rtl/rtwa_if.sv
// Input channel: one sample or update tick per beat.
interface rtwa_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [31:0]       now_ms;
  logic signed [7:0] sample_rssi;
  logic [23:0]       sample_tag;

  modport source (output valid, operation, now_ms, sample_rssi, sample_tag, input ready);
  modport sink   (input valid, operation, now_ms, sample_rssi, sample_tag, output ready);
endinterface

// Result channel: one average report per beat.
interface rtwa_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] average_rssi;
  logic [5:0]        sample_count;
  logic              had_samples;
  logic [1:0]        strength_band;
  logic [8:0]        hue_degrees;

  modport source (output valid, average_rssi, sample_count, had_samples, strength_band,
                  hue_degrees, input ready);
  modport sink   (input valid, average_rssi, sample_count, had_samples, strength_band,
                  hue_degrees, output ready);
endinterface

// Configuration write channel.
interface rtwa_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/rssi_time_window_average_top.sv
// Keeps the last RING_DEPTH-1 tagged RSSI samples with their millisecond
// stamps in a single-port-read ring memory. A sample beat whose tag matches
// magic_tag is stored; the oldest entry is overwritten when the ring is full.
// An update beat walks the ring oldest to newest, one memory read per cycle,
// drops every entry older than window_ms (modular 32-bit age), and averages
// the rest with a bit-serial divider truncating toward zero, or takes empty_avg
// when none are left, then reports one result beat with the band and hue. The
// input accepts a new beat as soon as the previous one has been handed on; a
// result waits in its own output register until taken.
module rssi_time_window_average_top #(
  parameter int unsigned RING_DEPTH = rtwa_pkg::RING_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  rtwa_in_if.sink    item,
  rtwa_out_if.source result,
  rtwa_cfg_if.sink   cfg
);
  import rtwa_pkg::*;

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned SW = AW + 8;
  localparam int unsigned NW = AW + 7;
  localparam logic [AW-1:0] LAST = AW'(RING_DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_WALK = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] v);
    return (v == LAST) ? '0 : v + 1'b1;
  endfunction

  // Configuration registers.
  logic [15:0]       window_ms;
  logic [23:0]       magic_tag;
  logic signed [7:0] band_high;
  logic signed [7:0] band_mid;
  logic signed [7:0] band_low;
  logic signed [7:0] empty_avg;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ms <= WINDOW_MS_RST;
      magic_tag <= MAGIC_TAG_RST;
      band_high <= BAND_HIGH_RST;
      band_mid  <= BAND_MID_RST;
      band_low  <= BAND_LOW_RST;
      empty_avg <= EMPTY_AVG_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_WINDOW_MS: window_ms <= cfg.data[15:0];
        REG_MAGIC_TAG: magic_tag <= cfg.data;
        REG_BAND_HIGH: band_high <= cfg.data[7:0];
        REG_BAND_MID:  band_mid  <= cfg.data[7:0];
        REG_BAND_LOW:  band_low  <= cfg.data[7:0];
        REG_EMPTY_AVG: empty_avg <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // Control and walk state.
  logic [1:0]           state;
  logic [AW-1:0]        head;
  logic [AW-1:0]        tail;
  logic [AW-1:0]        walk_idx;
  logic                 rvalid;
  logic [31:0]          now_reg;
  logic signed [SW-1:0] sum;
  logic [AW-1:0]        total;
  logic signed [7:0]    avg;

  logic                 accept;
  logic                 wr_en;
  logic [AW-1:0]        head_inc;
  logic                 rd_en;
  slot_t                wr_slot;
  slot_t                rd_slot;
  logic [31:0]          age;
  logic                 stale;

  assign item.ready = (state == S_IDLE);
  assign accept     = item.valid && item.ready;
  assign wr_en      = accept && (item.operation == OP_SAMPLE) && (item.sample_tag == magic_tag);
  assign head_inc   = wrap_inc(head);
  assign rd_en      = (state == S_WALK) && (walk_idx != head);
  assign wr_slot    = '{rssi: item.sample_rssi, stamp: item.now_ms};
  assign age        = now_reg - rd_slot.stamp;
  assign stale      = age > {16'd0, window_ms};

  rtwa_ring #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_ring (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (head),
    .wr_data (wr_slot),
    .rd_en   (rd_en),
    .rd_addr (walk_idx),
    .rd_data (rd_slot)
  );

  // Divider on the magnitude of the sum; the sign is put back afterwards.
  logic          sum_neg;
  logic [SW-1:0] sum_mag;
  logic          div_start;
  logic          div_done;
  logic [NW-1:0] quo;
  logic [7:0]    quo8;

  assign sum_neg   = sum[SW-1];
  assign sum_mag   = sum_neg ? SW'(-sum) : SW'(sum);
  assign div_start = (state == S_WALK) && !rd_en && !rvalid && (total != '0);
  assign quo8      = quo[7:0];

  rtwa_div #(
    .NW (NW),
    .DW (AW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_mag[NW-1:0]),
    .divisor  (total),
    .done     (div_done),
    .quotient (quo)
  );

  // Sequencer: store samples, walk the ring, divide, report.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      head   <= '0;
      tail   <= '0;
      rvalid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          rvalid <= 1'b0;
          if (wr_en) begin
            head <= head_inc;
            if (head_inc == tail) begin
              tail <= wrap_inc(tail);
            end
          end
          if (accept && (item.operation == OP_UPDATE)) begin
            now_reg  <= item.now_ms;
            walk_idx <= tail;
            sum      <= '0;
            total    <= '0;
            state    <= S_WALK;
          end
        end
        S_WALK: begin
          rvalid <= rd_en;
          if (rd_en) begin
            walk_idx <= wrap_inc(walk_idx);
          end
          if (rvalid) begin
            if (stale) begin
              tail <= wrap_inc(tail);
            end else begin
              sum   <= sum + SW'(rd_slot.rssi);
              total <= total + 1'b1;
            end
          end else if (!rd_en) begin
            if (total == '0) begin
              avg   <= empty_avg;
              state <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            avg   <= sum_neg ? -quo8 : quo8;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result.valid || result.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Band and hue of the finished average.
  logic [1:0]         band;
  logic [8:0]         hue;
  logic [COUNT_W-1:0] count_sat;

  always_comb begin
    if (avg > band_high) begin
      band = BAND_STRONG;
      hue  = HUE_STRONG;
    end else if (avg > band_mid) begin
      band = BAND_GOOD;
      hue  = HUE_GOOD;
    end else if (avg > band_low) begin
      band = BAND_FAIR;
      hue  = HUE_FAIR;
    end else begin
      band = BAND_WEAK;
      hue  = HUE_WEAK;
    end
    count_sat = (32'(total) > 32'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(total);
  end

  // Output register; a result waits here until the sink takes the beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if ((state == S_DONE) && (!result.valid || result.ready)) begin
      result.valid         <= 1'b1;
      result.average_rssi  <= avg;
      result.sample_count  <= count_sat;
      result.had_samples   <= (total != '0);
      result.strength_band <= band;
      result.hue_degrees   <= hue;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/rtwa_ring.sv
module rtwa_ring #(
  parameter int unsigned DEPTH = rtwa_pkg::RING_DEPTH_DEFAULT,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic            clk,
  input  logic            wr_en,
  input  logic [AW-1:0]   wr_addr,
  input  rtwa_pkg::slot_t wr_data,
  input  logic            rd_en,
  input  logic [AW-1:0]   rd_addr,
  output rtwa_pkg::slot_t rd_data
);
  import rtwa_pkg::*;

  slot_t mem [DEPTH];

  // One write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // One read port with registered data.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/rtwa_div.sv
module rtwa_div #(
  parameter int unsigned NW = 13,
  parameter int unsigned DW = 6
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [NW-1:0] quotient
);
  localparam int unsigned STEP_W = $clog2(NW + 1);

  logic              busy;
  logic [DW:0]       rem;
  logic [NW-1:0]     quo;
  logic [DW-1:0]     dvs;
  logic [STEP_W-1:0] step;
  logic [DW:0]       shifted;
  logic              fits;

  // One restoring step: bring down the next dividend bit and try a subtract.
  always_comb begin
    shifted = {rem[DW-1:0], quo[NW-1]};
    fits    = shifted >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
      step <= STEP_W'(NW);
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy) begin
      rem  <= fits ? (shifted - {1'b0, dvs}) : shifted;
      quo  <= {quo[NW-2:0], fits};
      step <= step - 1'b1;
      if (step == STEP_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  assign quotient = quo;

endmodule
